### rtl/nand_command_sequencer_defines.svh
// Assertion macros shared by the nand_command_sequencer RTL.
`ifndef NAND_COMMAND_SEQUENCER_DEFINES_SVH
`define NAND_COMMAND_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
`define NSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NSQ_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NSQ_ASSERT(label, prop, msg)
`define NSQ_NEVER(label, expr, msg)
`endif
`endif

### rtl/nsq_pkg.sv
package nsq_pkg;

    localparam int PAGE_BYTES_DEFAULT  = 2048;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [2:0] CMD_READ        = 3'd0;
    localparam logic [2:0] CMD_PROG_BEGIN  = 3'd1;
    localparam logic [2:0] CMD_PROG_BYTE   = 3'd2;
    localparam logic [2:0] CMD_PROG_END    = 3'd3;
    localparam logic [2:0] CMD_ERASE       = 3'd4;
    localparam logic [2:0] CMD_FLASH_REPLY = 3'd5;

    localparam logic [2:0] KIND_CMD   = 3'd0;
    localparam logic [2:0] KIND_ADDR  = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_WAIT  = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;
    localparam logic [2:0] KIND_REPLY = 3'd5;
    localparam logic [2:0] KIND_ERROR = 3'd6;

    localparam logic [7:0] NAND_READ_SETUP  = 8'h00;
    localparam logic [7:0] NAND_READ_CONFIRM = 8'h30;
    localparam logic [7:0] NAND_PROG_SETUP  = 8'h80;
    localparam logic [7:0] NAND_PROG_CONFIRM = 8'h10;
    localparam logic [7:0] NAND_ERASE_SETUP = 8'h60;
    localparam logic [7:0] NAND_ERASE_CONFIRM = 8'hD0;
    localparam logic [7:0] NAND_READ_STATUS = 8'h70;
    localparam logic [7:0] ERASE_ROW_MASK   = 8'hC0;

    localparam logic [3:0] LEN_READ       = 4'd9;
    localparam logic [3:0] LEN_PROG_BEGIN = 4'd6;
    localparam logic [3:0] LEN_PROG_END   = 4'd4;
    localparam logic [3:0] LEN_ERASE      = 4'd8;
    localparam logic [3:0] LEN_SINGLE     = 4'd1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
    } nsq_req_t;

    typedef struct packed {
        logic [2:0] cycle_kind;
        logic [7:0] bus_byte;
        logic       chip_enable;
        logic       reply_fail;
        logic       last;
    } nsq_rsp_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_PROG_BEGIN,
        OP_PROG_BYTE,
        OP_PROG_END,
        OP_ERASE,
        OP_REPLY,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] col;
        logic [23:0] row;
        logic [7:0]  data;
        logic        fail;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } nsq_qstat_t;

endpackage

### rtl/nsq_front.sv
module nsq_front #(
    parameter int PAGE_BYTES = nsq_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nsq_pkg::nsq_req_t req,
    input  logic             q_full,
    output logic             q_push,
    output nsq_pkg::job_t    q_job
);
    import nsq_pkg::*;

    // PAGE_BYTES must be a power of two, which the block does not enforce; column and row are a mask and a shift.
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int CNT_W      = $clog2(PAGE_BYTES + 1);

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_DATA,
        PEND_STATUS
    } pend_t;

    pend_t            pending_reg, pending_next;
    logic             open_reg, open_next;
    logic [CNT_W-1:0] written_reg, written_next;
    logic             accept;
    logic [31:0]      col_full;
    logic [31:0]      row_full;
    job_t             job;
    logic             enq;

    assign accept   = push && !q_full;
    assign col_full = req.byte_address & 32'(PAGE_BYTES - 1);
    assign row_full = req.byte_address >> PAGE_SHIFT;

    always_comb
    begin
        pending_next = pending_reg;
        open_next    = open_reg;
        written_next = written_reg;
        enq          = 1'b1;
        job.op       = OP_ERROR;
        job.col      = col_full[15:0];
        job.row      = row_full[23:0];
        job.data     = req.data_byte;
        job.fail     = 1'b0;
        case (req.cmd)
            CMD_READ:
            begin
                job.op       = OP_READ;
                open_next    = 1'b0;
                pending_next = PEND_DATA;
            end
            CMD_PROG_BEGIN:
            begin
                job.op       = OP_PROG_BEGIN;
                open_next    = 1'b1;
                written_next = '0;
            end
            CMD_PROG_BYTE:
            begin
                if (!open_reg) begin
                    job.op = OP_ERROR;
                end else if (written_reg < CNT_W'(PAGE_BYTES)) begin
                    job.op       = OP_PROG_BYTE;
                    written_next = written_reg + CNT_W'(1);
                end else begin
                    enq = 1'b0;
                end
            end
            CMD_PROG_END:
            begin
                if (!open_reg) begin
                    job.op = OP_ERROR;
                end else begin
                    job.op       = OP_PROG_END;
                    open_next    = 1'b0;
                    written_next = '0;
                    pending_next = PEND_STATUS;
                end
            end
            CMD_ERASE:
            begin
                job.op       = OP_ERASE;
                open_next    = 1'b0;
                pending_next = PEND_STATUS;
            end
            CMD_FLASH_REPLY:
            begin
                case (pending_reg)
                    PEND_DATA:   job.op = OP_REPLY;
                    PEND_STATUS:
                    begin
                        job.op   = OP_REPLY;
                        job.fail = req.data_byte[0];
                    end
                    default:     job.op = OP_ERROR;
                endcase
                pending_next = PEND_NONE;
            end
            default:
            begin
                job.op = OP_ERROR;
            end
        endcase
    end

    assign q_push = accept && enq;
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= PEND_NONE;
            open_reg    <= 1'b0;
            written_reg <= '0;
        end else if (accept) begin
            pending_reg <= pending_next;
            open_reg    <= open_next;
            written_reg <= written_next;
        end
    end

endmodule

### rtl/nsq_queue.sv
module nsq_queue #(
    parameter int DEPTH = nsq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  nsq_pkg::job_t      wr_job,
    input  logic               rd_en,
    output nsq_pkg::job_t      rd_job,
    output nsq_pkg::nsq_qstat_t stat
);
    import nsq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### rtl/nsq_back.sv
module nsq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  nsq_pkg::job_t      job,
    input  nsq_pkg::nsq_qstat_t q_stat,
    output logic               q_pop,
    output nsq_pkg::nsq_rsp_t  rsp,
    output logic               empty,
    input  logic               pop
);
    import nsq_pkg::*;

    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    nsq_rsp_t   out_reg;
    nsq_rsp_t   beat;
    logic [3:0] len;
    logic       load;

    assign load = (!out_valid_reg || pop) && !q_stat.empty;

    always_comb
    begin
        beat             = '0;
        beat.chip_enable = 1'b1;
        len              = LEN_SINGLE;
        case (job.op)
            OP_READ:
            begin
                len = LEN_READ;
                case (step_reg)
                    4'd0:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_READ_SETUP;
                    end
                    4'd1:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.col[7:0];
                    end
                    4'd2:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.col[15:8];
                    end
                    4'd3:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[7:0];
                    end
                    4'd4:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[15:8];
                    end
                    4'd5:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[23:16];
                    end
                    4'd6:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_READ_CONFIRM;
                    end
                    4'd7:    beat.cycle_kind = KIND_WAIT;
                    default: beat.cycle_kind = KIND_READ;
                endcase
            end
            OP_PROG_BEGIN:
            begin
                len = LEN_PROG_BEGIN;
                case (step_reg)
                    4'd0:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_PROG_SETUP;
                    end
                    4'd3:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[7:0];
                    end
                    4'd4:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[15:8];
                    end
                    4'd5:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[23:16];
                    end
                    default: beat.cycle_kind = KIND_ADDR;
                endcase
            end
            OP_PROG_BYTE:
            begin
                beat.cycle_kind = KIND_WRITE;
                beat.bus_byte   = job.data;
            end
            OP_PROG_END:
            begin
                len = LEN_PROG_END;
                case (step_reg)
                    4'd0:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_PROG_CONFIRM;
                    end
                    4'd1:    beat.cycle_kind = KIND_WAIT;
                    4'd2:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_READ_STATUS;
                    end
                    default: beat.cycle_kind = KIND_READ;
                endcase
            end
            OP_ERASE:
            begin
                len = LEN_ERASE;
                case (step_reg)
                    4'd0:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_ERASE_SETUP;
                    end
                    4'd1:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[7:0] & ERASE_ROW_MASK;
                    end
                    4'd2:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[15:8];
                    end
                    4'd3:
                    begin
                        beat.cycle_kind = KIND_ADDR;
                        beat.bus_byte   = job.row[23:16];
                    end
                    4'd4:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_ERASE_CONFIRM;
                    end
                    4'd5:    beat.cycle_kind = KIND_WAIT;
                    4'd6:
                    begin
                        beat.cycle_kind = KIND_CMD;
                        beat.bus_byte   = NAND_READ_STATUS;
                    end
                    default: beat.cycle_kind = KIND_READ;
                endcase
            end
            OP_REPLY:
            begin
                beat.cycle_kind  = KIND_REPLY;
                beat.bus_byte    = job.data;
                beat.chip_enable = 1'b0;
                beat.reply_fail  = job.fail;
            end
            default:
            begin
                beat.cycle_kind  = KIND_ERROR;
                beat.chip_enable = 1'b0;
            end
        endcase
        beat.last = (step_reg == len - 4'd1);
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            step_next      = beat.last ? 4'd0 : step_reg + 4'd1;
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    assign q_pop = load && beat.last;
    assign rsp   = out_reg;
    assign empty = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= beat;
        end
    end

endmodule

### rtl/nand_command_sequencer.sv
// An accepted item is written to the job queue; its first bus beat is then registered onto rsp once the output is free.
// The back sequencer emits one beat per cycle while a job is queued and pop keeps the output free;
// the beats per item are: read 9, erase 8, program begin 6, program end 4, others 1.
// A program byte beyond the page is accepted but yields no beat.
// Reset clears the request state, the job queue and the output valid flag at once.
`include "nand_command_sequencer_defines.svh"

module nand_command_sequencer #(
    parameter int PAGE_BYTES  = nsq_pkg::PAGE_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = nsq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  nsq_pkg::nsq_req_t req,
    output logic              empty,
    input  logic              pop,
    output nsq_pkg::nsq_rsp_t rsp
);
    import nsq_pkg::*;

    logic       q_push;
    job_t       q_wr_job;
    logic       q_pop;
    job_t       q_rd_job;
    nsq_qstat_t q_stat;

    assign full = q_stat.full;

    nsq_front #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .req    (req),
        .q_full (q_stat.full),
        .q_push (q_push),
        .q_job  (q_wr_job)
    );

    nsq_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (q_wr_job),
        .rd_en  (q_pop),
        .rd_job (q_rd_job),
        .stat   (q_stat)
    );

    nsq_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (q_rd_job),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .rsp    (rsp),
        .empty  (empty),
        .pop    (pop)
    );

    `NSQ_NEVER(a_queue_full_empty, q_stat.full && q_stat.empty, "queue full and empty at once")
    `NSQ_ASSERT(a_reply_shape, !empty && rsp.cycle_kind == KIND_REPLY |-> !rsp.chip_enable && rsp.last, "host reply beat malformed")
    `NSQ_ASSERT(a_fail_only_reply, !empty && rsp.reply_fail |-> rsp.cycle_kind == KIND_REPLY, "failure flag outside a reply")
    `NSQ_ASSERT(a_pop_needs_job, q_pop |-> !q_stat.empty, "job retired from an empty queue")

endmodule
